// ===== rtl/mtdp_pkg.sv =====
// Shared constants for the meter teleinformation dataset parser.
// Control characters, status codes, default sizes and register reset values.
// No dependencies.
package mtdp_pkg;

    // Default sizes
    localparam int LINE_DEPTH_DEF  = 64;
    localparam int LABEL_MAX_DEF   = 8;
    localparam int VALUE_MAX_DEF   = 16;
    localparam int LABEL_COUNT_DEF = 5;

    // Register file
    localparam int NUM_REGS  = 5;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Field widths
    localparam int CHAR_W   = 7;
    localparam int STATUS_W = 3;
    localparam int LABEL_W  = 3;
    localparam int SUM_W    = 6;
    localparam int SEP_W    = 3;

    // Control characters, parity already stripped
    localparam logic [CHAR_W-1:0] CH_STX = 7'h02;
    localparam logic [CHAR_W-1:0] CH_ETX = 7'h03;
    localparam logic [CHAR_W-1:0] CH_TAB = 7'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
    localparam logic [CHAR_W-1:0] CK_OFFSET = 7'h20;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNEXPECT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NAME_LONG = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CK_BAD    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEP_BAD   = 3'd4;

    // Wanted label reset values
    localparam logic [REG_W-1:0] NAME0_RST = 64'd1129530433;
    localparam logic [REG_W-1:0] NAME1_RST = 64'd211850973769;
    localparam logic [REG_W-1:0] NAME2_RST = 64'd211850973781;
    localparam logic [REG_W-1:0] NAME3_RST = 64'd91621639997779;
    localparam logic [REG_W-1:0] NAME4_RST = 64'd1414742341;

endpackage

// ===== rtl/meter_teleinfo_dataset_parser.sv =====
// Top level of the meter teleinformation dataset parser.
// Depends on mtdp_pkg (constants); holds the line buffer memory.
//
//  channel  | dir | beat fields (low bit first)                       | handshake
//  ---------+-----+---------------------------------------------------+-----------------
//  s_       | in  | tdata: rx_byte[7:0]                               | s_tvalid/s_tready
//  m_       | out | tdata: status, label_index, data_char, char_valid | m_tvalid/m_tready
//           |     | tlast: last                                       |
//  cfg_     | in  | cfg_index (register), cfg_data (64-bit label)     | cfg_valid/cfg_ready
//
// Flow: an input byte is taken whenever the result register is free or draining
// and the readout sequencer is idle. A good dataset's CR starts the value readout:
// each character goes through SQ_READ then SQ_EMIT (registered read of the single
// line buffer read port), and no input byte is taken until the readout has ended.
// Reset: aresetn is synchronous, active low; clears control state and loads label reset values.
// The line buffer is not cleared; every entry read was written in the same dataset.
// Stalls: m_tready low holds the result register; input stalls while it is full.
module meter_teleinfo_dataset_parser #(
    parameter int LINE_DEPTH  = mtdp_pkg::LINE_DEPTH_DEF,
    parameter int LABEL_MAX   = mtdp_pkg::LABEL_MAX_DEF,
    parameter int VALUE_MAX   = mtdp_pkg::VALUE_MAX_DEF,
    parameter int LABEL_COUNT = mtdp_pkg::LABEL_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input byte stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // rx_byte[7:0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // status[2:0], label_index[5:3],
                                                      // data_char[12:6], char_valid[13]
    output logic                           m_tlast,   // last
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mtdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mtdp_pkg::REG_W-1:0]     cfg_data
);

    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam int NAME_W = LABEL_MAX * 8;
    localparam int LEN_W  = $clog2(VALUE_MAX + 1);
    localparam int LW     = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;
    localparam int CW     = mtdp_pkg::CHAR_W;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FRAME, PH_NAME, PH_SKIP, PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        SQ_RX, SQ_READ, SQ_EMIT, SQ_FLUSH
    } seq_t;

    // ---------------- state ----------------
    phase_t                        phase_reg, phase_next;
    seq_t                          sq_reg, sq_next;
    logic [mtdp_pkg::REG_W-1:0]    wanted_reg [LABEL_COUNT];
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [mtdp_pkg::SEP_W-1:0]    sep_cnt_reg, sep_cnt_next;
    logic [CNT_W-1:0]              sep_pos_reg [3];
    logic [CNT_W-1:0]              sep_pos_next [3];
    logic [mtdp_pkg::LABEL_W-1:0]  match_reg, match_next;
    logic [NAME_W-1:0]             name_reg, name_next;
    logic [mtdp_pkg::SUM_W-1:0]    sum_reg, sum_next;     // checksum of all but newest byte
    logic [CW-1:0]                 last_reg, last_next;   // newest stored byte
    logic [ADDR_W-1:0]             addr_reg, addr_next;
    logic [LEN_W-1:0]              left_reg, left_next;
    logic [CW-1:0]                 pend_reg, pend_next;   // char held until its last flag is known
    logic                          pend_v_reg, pend_v_next;

    // result register
    logic                          mv_reg, mv_next;
    logic [mtdp_pkg::STATUS_W-1:0] mstat_reg, mstat_next;
    logic [mtdp_pkg::LABEL_W-1:0]  mlbl_reg, mlbl_next;
    logic [CW-1:0]                 mchar_reg, mchar_next;
    logic                          mcv_reg, mcv_next;
    logic                          mlast_reg, mlast_next;

    // line buffer
    logic [CW-1:0]                 line_mem [LINE_DEPTH];
    logic [CW-1:0]                 rd_data_reg;
    logic                          mem_we, mem_re;
    logic [CW-1:0]                 mem_wdata;

    // ---------------- handshake ----------------
    logic          out_free, accept;
    logic [CW-1:0] rx;

    assign out_free  = !mv_reg || m_tready;
    assign s_tready  = (sq_reg == SQ_RX) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign rx        = s_tdata[CW-1:0];
    assign cfg_ready = 1'b1;

    assign m_tvalid = mv_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {2'b00, mcv_reg, mchar_reg, mlbl_reg, mstat_reg};

    // ---------------- name match ----------------
    logic [mtdp_pkg::REG_W-1:0]   name64;
    logic                         name_hit;
    logic [mtdp_pkg::LABEL_W-1:0] name_idx;

    assign name64 = mtdp_pkg::REG_W'(name_reg);

    always_comb begin
        name_hit = 1'b0;
        name_idx = '0;
        // scan downward so the lowest matching label wins
        for (int i = LABEL_COUNT - 1; i >= 0; i--) begin
            if (wanted_reg[i] != '0 && wanted_reg[i] == name64) begin
                name_hit = 1'b1;
                name_idx = mtdp_pkg::LABEL_W'(i);
            end
        end
    end

    // ---------------- dataset checks ----------------
    logic [CW-1:0]    last_term;
    logic [CW-1:0]    ck_calc;
    logic             ck_ok, sep_ok;
    logic [CNT_W-1:0] sel_lo, sel_hi;
    logic [LW-1:0]    v_start, v_stop, v_len_raw;
    logic [LEN_W-1:0] v_len;

    // tabs are stored as zero but count as a tab in the sum
    assign last_term = (last_reg == '0) ? mtdp_pkg::CH_TAB : last_reg;
    assign ck_calc   = CW'(sum_reg) + mtdp_pkg::CK_OFFSET;
    assign ck_ok     = (ck_calc == last_reg);
    assign sep_ok    = (sep_cnt_reg == 3'd2) || (sep_cnt_reg == 3'd3);

    // value lies between the last two recorded separators
    assign sel_lo    = (sep_cnt_reg == 3'd3) ? sep_pos_reg[1] : sep_pos_reg[0];
    assign sel_hi    = (sep_cnt_reg == 3'd3) ? sep_pos_reg[2] : sep_pos_reg[1];
    assign v_start   = LW'(sel_lo) + LW'(1);
    assign v_stop    = LW'(sel_hi);
    assign v_len_raw = (v_stop > v_start) ? (v_stop - v_start) : '0;
    assign v_len     = (v_len_raw > LW'(VALUE_MAX)) ? LEN_W'(VALUE_MAX) : LEN_W'(v_len_raw);

    // ---------------- next state ----------------
    always_comb begin
        phase_next  = phase_reg;
        sq_next     = sq_reg;
        fill_next   = fill_reg;
        sep_cnt_next = sep_cnt_reg;
        for (int i = 0; i < 3; i++) begin
            sep_pos_next[i] = sep_pos_reg[i];
        end
        match_next  = match_reg;
        name_next   = name_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = rx;

        mv_next    = mv_reg && !m_tready;
        mstat_next = mstat_reg;
        mlbl_next  = mlbl_reg;
        mchar_next = mchar_reg;
        mcv_next   = mcv_reg;
        mlast_next = mlast_reg;

        case (sq_reg)
            SQ_RX: begin
                if (accept) begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (rx == mtdp_pkg::CH_STX) begin
                                phase_next = PH_FRAME;
                            end
                        end
                        PH_FRAME: begin
                            if (rx == mtdp_pkg::CH_LF) begin
                                fill_next    = '0;
                                sep_cnt_next = '0;
                                sum_next     = '0;
                                name_next    = '0;
                                phase_next   = PH_NAME;
                            end else if (rx == mtdp_pkg::CH_ETX) begin
                                phase_next = PH_IDLE;
                            end else begin
                                mv_next    = 1'b1;
                                mstat_next = mtdp_pkg::ST_UNEXPECT;
                                mlbl_next  = '0;
                                mchar_next = '0;
                                mcv_next   = 1'b0;
                                mlast_next = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_NAME: begin
                            if (rx == mtdp_pkg::CH_TAB) begin
                                if (name_hit) begin
                                    sep_pos_next[0] = fill_reg;
                                    sep_cnt_next    = 3'd1;
                                    mem_we          = 1'b1;
                                    mem_wdata       = '0;
                                    if (fill_reg != '0) begin
                                        sum_next = sum_reg + last_term[mtdp_pkg::SUM_W-1:0];
                                    end
                                    last_next  = '0;
                                    fill_next  = fill_reg + CNT_W'(1);
                                    match_next = name_idx;
                                    phase_next = PH_BODY;
                                end else begin
                                    fill_next  = '0;
                                    phase_next = PH_SKIP;
                                end
                            end else if (fill_reg >= CNT_W'(LABEL_MAX)) begin
                                mv_next    = 1'b1;
                                mstat_next = mtdp_pkg::ST_NAME_LONG;
                                mlbl_next  = '0;
                                mchar_next = '0;
                                mcv_next   = 1'b0;
                                mlast_next = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                mem_we = 1'b1;
                                for (int k = 0; k < LABEL_MAX; k++) begin
                                    if (fill_reg == CNT_W'(k)) begin
                                        name_next[k*8 +: 8] = {1'b0, rx};
                                    end
                                end
                                if (fill_reg != '0) begin
                                    sum_next = sum_reg + last_term[mtdp_pkg::SUM_W-1:0];
                                end
                                last_next = rx;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        PH_SKIP: begin
                            if (rx == mtdp_pkg::CH_CR) begin
                                phase_next = PH_FRAME;
                            end
                        end
                        PH_BODY: begin
                            if (rx == mtdp_pkg::CH_CR) begin
                                if (!ck_ok || !sep_ok) begin
                                    mv_next    = 1'b1;
                                    mstat_next = ck_ok ? mtdp_pkg::ST_SEP_BAD
                                                       : mtdp_pkg::ST_CK_BAD;
                                    mlbl_next  = '0;
                                    mchar_next = '0;
                                    mcv_next   = 1'b0;
                                    mlast_next = 1'b1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next   = PH_FRAME;
                                    sep_cnt_next = '0;
                                    if (v_len == '0) begin
                                        // empty value: one ok result, no char
                                        mv_next    = 1'b1;
                                        mstat_next = mtdp_pkg::ST_OK;
                                        mlbl_next  = match_reg;
                                        mchar_next = '0;
                                        mcv_next   = 1'b0;
                                        mlast_next = 1'b1;
                                    end else begin
                                        addr_next   = ADDR_W'(v_start);
                                        left_next   = v_len;
                                        pend_v_next = 1'b0;
                                        sq_next     = SQ_READ;
                                    end
                                end
                            end else if (fill_reg >= CNT_W'(LINE_DEPTH)) begin
                                // buffer overflow drops the frame quietly
                                phase_next = PH_IDLE;
                            end else begin
                                mem_we = 1'b1;
                                if (rx == mtdp_pkg::CH_TAB) begin
                                    for (int i = 0; i < 3; i++) begin
                                        if (sep_cnt_reg == mtdp_pkg::SEP_W'(i)) begin
                                            sep_pos_next[i] = fill_reg;
                                        end
                                    end
                                    if (sep_cnt_reg != 3'd7) begin
                                        sep_cnt_next = sep_cnt_reg + 3'd1;
                                    end
                                    mem_wdata = '0;
                                    last_next = '0;
                                end else begin
                                    last_next = rx;
                                end
                                if (fill_reg != '0) begin
                                    sum_next = sum_reg + last_term[mtdp_pkg::SUM_W-1:0];
                                end
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            SQ_READ: begin
                mem_re  = 1'b1;
                sq_next = SQ_EMIT;
            end
            SQ_EMIT: begin
                if (out_free) begin
                    if (rd_data_reg == '0) begin
                        // stored zero ends the value early
                        mv_next    = 1'b1;
                        mstat_next = mtdp_pkg::ST_OK;
                        mlbl_next  = match_reg;
                        mchar_next = pend_v_reg ? pend_reg : '0;
                        mcv_next   = pend_v_reg;
                        mlast_next = 1'b1;
                        sq_next    = SQ_RX;
                    end else begin
                        if (pend_v_reg) begin
                            mv_next    = 1'b1;
                            mstat_next = mtdp_pkg::ST_OK;
                            mlbl_next  = match_reg;
                            mchar_next = pend_reg;
                            mcv_next   = 1'b1;
                            mlast_next = 1'b0;
                        end
                        pend_next   = rd_data_reg;
                        pend_v_next = 1'b1;
                        left_next   = left_reg - LEN_W'(1);
                        addr_next   = addr_reg + ADDR_W'(1);
                        sq_next     = (left_reg == LEN_W'(1)) ? SQ_FLUSH : SQ_READ;
                    end
                end
            end
            SQ_FLUSH: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mstat_next = mtdp_pkg::ST_OK;
                    mlbl_next  = match_reg;
                    mchar_next = pend_reg;
                    mcv_next   = 1'b1;
                    mlast_next = 1'b1;
                    sq_next    = SQ_RX;
                end
            end
            default: begin
                sq_next = SQ_RX;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            sq_reg      <= SQ_RX;
            fill_reg    <= '0;
            sep_cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                sep_pos_reg[i] <= '0;
            end
            match_reg   <= '0;
            pend_v_reg  <= 1'b0;
            mv_reg      <= 1'b0;
            for (int i = 0; i < LABEL_COUNT; i++) begin
                case (i)
                    0: wanted_reg[i] <= mtdp_pkg::NAME0_RST;
                    1: wanted_reg[i] <= mtdp_pkg::NAME1_RST;
                    2: wanted_reg[i] <= mtdp_pkg::NAME2_RST;
                    3: wanted_reg[i] <= mtdp_pkg::NAME3_RST;
                    default: wanted_reg[i] <= mtdp_pkg::NAME4_RST;
                endcase
            end
        end else begin
            phase_reg   <= phase_next;
            sq_reg      <= sq_next;
            fill_reg    <= fill_next;
            sep_cnt_reg <= sep_cnt_next;
            for (int i = 0; i < 3; i++) begin
                sep_pos_reg[i] <= sep_pos_next[i];
            end
            match_reg   <= match_next;
            pend_v_reg  <= pend_v_next;
            mv_reg      <= mv_next;
            // labels beyond LABEL_COUNT are never compared, writes there drop
            if (cfg_valid && cfg_ready) begin
                for (int i = 0; i < LABEL_COUNT; i++) begin
                    if (cfg_index == mtdp_pkg::CFG_IDX_W'(i)) begin
                        wanted_reg[i] <= cfg_data;
                    end
                end
            end
        end
        // payload
        name_reg  <= name_next;
        sum_reg   <= sum_next;
        last_reg  <= last_next;
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        pend_reg  <= pend_next;
        mstat_reg <= mstat_next;
        mlbl_reg  <= mlbl_next;
        mchar_reg <= mchar_next;
        mcv_reg   <= mcv_next;
        mlast_reg <= mlast_next;
    end

    // ---------------- line buffer ----------------
    // writes land at the fill position; reads come only from the readout sequencer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[fill_reg[ADDR_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= line_mem[addr_reg];
        end
    end

endmodule

// ===== verif/meter_teleinfo_dataset_parser_test.sv =====
// Self-checking testbench for meter_teleinfo_dataset_parser: byte stream in, result beats out.
// Holds its own parser prediction and compares every result beat against it.
// Depends on mtdp_pkg (control characters, status codes, sizes, label reset values).
`timescale 1ns / 100ps

module meter_teleinfo_dataset_parser_test;

    // Parser phases as tracked by the prediction
    typedef enum logic [2:0] {WAIT_STX, WAIT_LF, IN_NAME, SKIP_LINE, IN_BODY} parse_phase_t;

    // One result beat: status, label_index, data_char, char_valid, tlast
    typedef struct packed {
        logic [mtdp_pkg::STATUS_W-1:0] status;
        logic [mtdp_pkg::LABEL_W-1:0]  label;
        logic [mtdp_pkg::CHAR_W-1:0]   ch;
        logic                          vld;
        logic                          last;
    } beat_t;

    // Register indexes on the config channel
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_NAME0   = mtdp_pkg::CFG_IDX_W'(0);
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_NAME1   = mtdp_pkg::CFG_IDX_W'(1);
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_NAME2   = mtdp_pkg::CFG_IDX_W'(2);
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_NAME3   = mtdp_pkg::CFG_IDX_W'(3);
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_NAME4   = mtdp_pkg::CFG_IDX_W'(4);
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_UNUSED5 = mtdp_pkg::CFG_IDX_W'(5);
    localparam logic [mtdp_pkg::CFG_IDX_W-1:0] IDX_UNUSED7 = mtdp_pkg::CFG_IDX_W'(7);

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mtdp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mtdp_pkg::REG_W-1:0]     cfg_data;

    // Predicted parser state
    parse_phase_t                   ph;
    logic [mtdp_pkg::CHAR_W-1:0]    line_buf [mtdp_pkg::LINE_DEPTH_DEF];
    int                             fill;
    int                             seps;
    int                             sep_at [3];
    logic [mtdp_pkg::LABEL_W-1:0]   hit_label;
    logic [mtdp_pkg::REG_W-1:0]     label_reg [mtdp_pkg::NUM_REGS];

    beat_t                          owed_beats [$];   // result beats still to come, oldest first
    logic [7:0]                     line_bytes [$];   // bytes built up for the next send
    int                             line_sum;         // running checksum since the last LF
    int                             bytes_sent;
    int                             miss_count;

    // Traffic shaping knobs
    bit                             tx_idle_on = 1'b1;
    bit                             rx_idle_on = 1'b1;
    int                             rx_hold_len = 0;
    int                             rx_stall_left = 0;

    always #5 aclk = ~aclk;

    meter_teleinfo_dataset_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic void owe_status(input logic [mtdp_pkg::STATUS_W-1:0] code);
        beat_t b;
        b = '0;
        b.status = code;
        b.last = 1'b1;
        owed_beats.push_back(b);
        ph = WAIT_STX;
    endfunction

    // Tab after the name: look the name up among the wanted labels
    function automatic void close_name();
        logic [mtdp_pkg::REG_W-1:0] packed_name;
        packed_name = '0;
        for (int k = 0; k < fill && k < 8; k++) packed_name[8*k +: 8] = {1'b0, line_buf[k]};
        for (int i = 0; i < mtdp_pkg::LABEL_COUNT_DEF && i < mtdp_pkg::NUM_REGS; i++) begin
            if (label_reg[i] != '0 && label_reg[i] == packed_name) begin
                sep_at[0] = fill;
                seps = 1;
                line_buf[fill % mtdp_pkg::LINE_DEPTH_DEF] = '0;
                fill++;
                hit_label = mtdp_pkg::LABEL_W'(i);
                ph = IN_BODY;
                return;
            end
        end
        fill = 0;
        ph = SKIP_LINE;
    endfunction

    // CR of a wanted dataset: checksum, separator count, then the value characters
    function automatic void close_dataset();
        int sum;
        int start;
        int stop;
        int len;
        logic [mtdp_pkg::CHAR_W-1:0] vals [$];
        beat_t b;
        sum = 0;
        for (int k = 0; k + 1 < fill && k < mtdp_pkg::LINE_DEPTH_DEF; k++)
            sum += (line_buf[k] == '0) ? 9 : int'(line_buf[k]);
        if (((sum & 'h3F) + 'h20) != int'(line_buf[(fill - 1) % mtdp_pkg::LINE_DEPTH_DEF])) begin
            owe_status(mtdp_pkg::ST_CK_BAD);
        end else if (seps != 2 && seps != 3) begin
            owe_status(mtdp_pkg::ST_SEP_BAD);
        end else begin
            start = sep_at[seps - 2] + 1;
            stop = sep_at[seps - 1];
            len = (stop > start) ? stop - start : 0;
            if (len > mtdp_pkg::VALUE_MAX_DEF) len = mtdp_pkg::VALUE_MAX_DEF;
            for (int k = 0; k < len; k++) begin
                if (line_buf[(start + k) % mtdp_pkg::LINE_DEPTH_DEF] == '0) break;
                vals.push_back(line_buf[(start + k) % mtdp_pkg::LINE_DEPTH_DEF]);
            end
            b = '0;
            b.status = mtdp_pkg::ST_OK;
            b.label = hit_label;
            if (vals.size() == 0) begin
                // empty value: one beat with no character
                b.last = 1'b1;
                owed_beats.push_back(b);
            end else begin
                for (int k = 0; k < vals.size(); k++) begin
                    b.ch = vals[k];
                    b.vld = 1'b1;
                    b.last = (k == vals.size() - 1);
                    owed_beats.push_back(b);
                end
            end
            ph = WAIT_LF;
            seps = 0;
        end
    endfunction

    // Advance the predicted parser by one accepted byte
    function automatic void parse_byte(input logic [7:0] raw);
        logic [mtdp_pkg::CHAR_W-1:0] rx;
        rx = raw[6:0];   // parity bit dropped
        case (ph)
            WAIT_STX: begin
                if (rx == mtdp_pkg::CH_STX) ph = WAIT_LF;
            end
            WAIT_LF: begin
                if (rx == mtdp_pkg::CH_LF) begin
                    fill = 0;
                    seps = 0;
                    ph = IN_NAME;
                end else if (rx == mtdp_pkg::CH_ETX) begin
                    ph = WAIT_STX;
                end else begin
                    owe_status(mtdp_pkg::ST_UNEXPECT);
                end
            end
            IN_NAME: begin
                if (rx == mtdp_pkg::CH_TAB) begin
                    close_name();
                end else if (fill >= mtdp_pkg::LABEL_MAX_DEF) begin
                    owe_status(mtdp_pkg::ST_NAME_LONG);
                end else begin
                    line_buf[fill % mtdp_pkg::LINE_DEPTH_DEF] = rx;
                    fill++;
                end
            end
            SKIP_LINE: begin
                if (rx == mtdp_pkg::CH_CR) ph = WAIT_LF;
            end
            IN_BODY: begin
                if (rx == mtdp_pkg::CH_CR) begin
                    close_dataset();
                end else if (fill >= mtdp_pkg::LINE_DEPTH_DEF) begin
                    ph = WAIT_STX;   // overflow drops the dataset silently
                end else begin
                    if (rx == mtdp_pkg::CH_TAB) begin
                        if (seps < 3) sep_at[seps] = fill;
                        if (seps < 7) seps++;
                        line_buf[fill] = '0;
                    end else begin
                        line_buf[fill] = rx;
                    end
                    fill++;
                end
            end
            default: ph = WAIT_STX;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Line builders
    //------------------------------------------------------------------
    // Queue one 7-bit character with a random parity bit
    function automatic void queue_char(input logic [mtdp_pkg::CHAR_W-1:0] c);
        line_bytes.push_back({1'($urandom_range(0, 1)), c});
        line_sum += (c == '0) ? 9 : int'(c);
    endfunction

    function automatic logic [mtdp_pkg::REG_W-1:0] rand_label(input int len);
        logic [mtdp_pkg::REG_W-1:0] v;
        v = '0;
        for (int k = 0; k < len; k++) v[8*k +: 8] = 8'($urandom_range(33, 126));
        return v;
    endfunction

    // STX if the parser sits between frames, then LF, name and the name tab
    function automatic void open_line(input logic [mtdp_pkg::REG_W-1:0] name);
        int n;
        n = 0;
        if (ph == WAIT_STX) queue_char(mtdp_pkg::CH_STX);
        queue_char(mtdp_pkg::CH_LF);
        line_sum = 0;
        for (int k = 0; k < 8; k++) if (name[8*k +: 8] != '0) n = k + 1;
        for (int k = 0; k < n; k++) queue_char(name[8*k +: 7]);
        queue_char(mtdp_pkg::CH_TAB);
    endfunction

    // Value characters: mostly printable, some control bytes and stored zeros
    function automatic void queue_value(input int len);
        int r;
        logic [mtdp_pkg::CHAR_W-1:0] c;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                c = '0;
            end else if (r < 9) begin
                c = mtdp_pkg::CHAR_W'($urandom_range(1, 31));
                if (c == mtdp_pkg::CH_TAB || c == mtdp_pkg::CH_CR) c = 7'h7F;
            end else begin
                c = mtdp_pkg::CHAR_W'($urandom_range(32, 126));
            end
            queue_char(c);
        end
    endfunction

    // Checksum byte (off by delta when nonzero) and CR
    function automatic void close_line(input int delta);
        queue_char(mtdp_pkg::CHAR_W'(((line_sum + delta) & 'h3F) + 'h20));
        queue_char(mtdp_pkg::CH_CR);
    endfunction

    function automatic int value_len();
        return ($urandom_range(0, 6) == 0) ? int'($urandom_range(14, 20))
                                           : int'($urandom_range(0, 8));
    endfunction

    // One random dataset or stray byte; mostly well formed
    function automatic void build_random_line();
        int r;
        int extra;
        logic [mtdp_pkg::CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 42) begin
            open_line(label_reg[$urandom_range(0, mtdp_pkg::NUM_REGS - 1)]);
            queue_value(value_len());
            queue_char(mtdp_pkg::CH_TAB);
            close_line(0);
        end else if (r < 57) begin
            // timestamped dataset: three separators
            open_line(label_reg[$urandom_range(0, mtdp_pkg::NUM_REGS - 1)]);
            queue_value($urandom_range(0, 13));
            queue_char(mtdp_pkg::CH_TAB);
            queue_value(value_len());
            queue_char(mtdp_pkg::CH_TAB);
            close_line(0);
        end else if (r < 65) begin
            // name nobody asked for, skipped up to its CR
            open_line(rand_label($urandom_range(1, 8)));
            queue_value($urandom_range(0, 10));
            queue_char(mtdp_pkg::CH_TAB);
            close_line(0);
        end else if (r < 73) begin
            open_line(label_reg[$urandom_range(0, mtdp_pkg::NUM_REGS - 1)]);
            queue_value($urandom_range(0, 8));
            queue_char(mtdp_pkg::CH_TAB);
            close_line($urandom_range(1, 63));
        end else if (r < 81) begin
            // one separator, or four and more
            open_line(label_reg[$urandom_range(0, mtdp_pkg::NUM_REGS - 1)]);
            queue_value($urandom_range(0, 5));
            extra = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(3, 8));
            for (int k = 0; k < extra; k++) begin
                queue_char(mtdp_pkg::CH_TAB);
                queue_value($urandom_range(0, 3));
            end
            close_line(0);
        end else if (r < 87) begin
            // name longer than the label limit
            if (ph == WAIT_STX) queue_char(mtdp_pkg::CH_STX);
            queue_char(mtdp_pkg::CH_LF);
            for (int k = int'($urandom_range(9, 12)); k > 0; k--)
                queue_char(mtdp_pkg::CHAR_W'($urandom_range(65, 90)));
        end else if (r < 94) begin
            c = mtdp_pkg::CHAR_W'($urandom_range(0, 127));
            if (c == mtdp_pkg::CH_LF || c == mtdp_pkg::CH_ETX) c = '0;
            queue_char(c);
        end else begin
            queue_char(mtdp_pkg::CH_ETX);
        end
    endfunction

    //------------------------------------------------------------------
    // Bus tasks
    //------------------------------------------------------------------
    // Offer one byte; ready is read at the falling edge, when all inputs have settled
    task automatic send_byte(input logic [7:0] raw);
        bit took;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= raw;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        bytes_sent++;
        parse_byte(raw);
    endtask

    task automatic send_queued();
        while (line_bytes.size() != 0) send_byte(line_bytes.pop_front());
    endtask

    task automatic write_label(input logic [mtdp_pkg::CFG_IDX_W-1:0] idx,
                               input logic [mtdp_pkg::REG_W-1:0] val);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        if (idx < mtdp_pkg::NUM_REGS) label_reg[idx] = val;
    endtask

    // Sender goes quiet until every owed beat is in
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge aclk);
        repeat (48) @(posedge aclk);
    endtask

    task automatic random_lines(input int n_items);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_items) begin
            build_random_line();
            send_queued();
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Idle bytes, empty value, stray byte between datasets, bad checksum
    task automatic test_directed();
        line_bytes.push_back(8'h80);
        line_bytes.push_back(8'hFF);
        send_queued();
        open_line(label_reg[IDX_NAME0]);
        queue_char(mtdp_pkg::CH_TAB);
        close_line(0);
        send_queued();
        queue_char(7'h51);
        send_queued();
        open_line(label_reg[IDX_NAME4]);
        queue_char(7'h37);
        queue_char(mtdp_pkg::CH_TAB);
        close_line($urandom_range(1, 63));
        send_queued();
    endtask

    task automatic test_reset_labels();
        random_lines(10);
    endtask

    // All-ones, full length, zero and duplicated labels; writes to unused indexes
    task automatic test_edge_labels();
        logic [mtdp_pkg::REG_W-1:0] dup;
        drain_results();
        dup = rand_label(1);
        write_label(IDX_NAME0, '1);
        write_label(IDX_NAME1, rand_label(8));
        write_label(IDX_NAME2, '0);
        write_label(IDX_NAME3, dup);
        write_label(IDX_NAME4, dup);
        write_label(IDX_UNUSED5, {$urandom, $urandom});
        write_label(IDX_UNUSED7, '1);
        cfg_valid <= 1'b0;
        // buffer overflow: body runs past the line store with no CR
        open_line(label_reg[IDX_NAME1]);
        for (int k = 0; k < 58; k++) queue_char(mtdp_pkg::CHAR_W'($urandom_range(32, 126)));
        send_queued();
        random_lines(6);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering bytes
    task automatic test_backpressure();
        rx_hold_len = 300;
        open_line(label_reg[IDX_NAME1]);
        queue_value(mtdp_pkg::VALUE_MAX_DEF);
        queue_char(mtdp_pkg::CH_TAB);
        close_line(0);
        send_queued();
        open_line(label_reg[IDX_NAME1]);
        queue_char(mtdp_pkg::CH_TAB);
        close_line(0);
        send_queued();
        drain_results();
    endtask

    task automatic test_random_labels();
        write_label(IDX_NAME0, rand_label(8));
        for (int i = 1; i < mtdp_pkg::NUM_REGS; i++) begin
            write_label(mtdp_pkg::CFG_IDX_W'(i), rand_label($urandom_range(1, 8)));
        end
        cfg_valid <= 1'b0;
        random_lines(6);
        // closing stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_lines(12);
    endtask

    //------------------------------------------------------------------
    // Result checker
    //------------------------------------------------------------------
    task automatic report_miss(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        miss_count++;
    endtask

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_beats.size() == 0) begin
                report_miss("beat with nothing owed, tdata", int'(m_tdata), 0);
            end else begin
                want = owed_beats.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_miss("status", int'(m_tdata[2:0]), int'(want.status));
                if (m_tdata[5:3] !== want.label)
                    report_miss("label_index", int'(m_tdata[5:3]), int'(want.label));
                if (m_tdata[12:6] !== want.ch)
                    report_miss("data_char", int'(m_tdata[12:6]), int'(want.ch));
                if (m_tdata[13] !== want.vld)
                    report_miss("char_valid", int'(m_tdata[13]), int'(want.vld));
                if (m_tlast !== want.last)
                    report_miss("last", int'(m_tlast), int'(want.last));
            end
        end
    end

    // Receiver: random stall bursts, plus the long hold-off when asked for
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_stall_left > 0) begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end else if (rx_hold_len > 0) begin
                m_tready <= 1'b0;
                rx_stall_left = rx_hold_len - 1;
                rx_hold_len = 0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                rx_stall_left = $urandom_range(0, 4);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ph = WAIT_STX;
        fill = 0;
        seps = 0;
        sep_at = '{0, 0, 0};
        hit_label = '0;
        for (int k = 0; k < mtdp_pkg::LINE_DEPTH_DEF; k++) line_buf[k] = '0;
        label_reg[IDX_NAME0] = mtdp_pkg::NAME0_RST;
        label_reg[IDX_NAME1] = mtdp_pkg::NAME1_RST;
        label_reg[IDX_NAME2] = mtdp_pkg::NAME2_RST;
        label_reg[IDX_NAME3] = mtdp_pkg::NAME3_RST;
        label_reg[IDX_NAME4] = mtdp_pkg::NAME4_RST;
        line_sum = 0;
        bytes_sent = 0;
        miss_count = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_reset_labels();
        test_edge_labels();
        test_backpressure();
        test_random_labels();
        drain_results();

        if (miss_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== meter_teleinfo_dataset_parser.f =====
rtl/mtdp_pkg.sv
rtl/meter_teleinfo_dataset_parser.sv
verif/meter_teleinfo_dataset_parser_test.sv
